// ===== design/cti_pkg.sv =====
// ----------------------------------------------------------------------------
// cti_pkg
// Types and codes shared by the capacitance table interpolator files.
// ----------------------------------------------------------------------------
package cti_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned DivSteps = 32;

  // func codes of an input item
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // region codes of a result item
  localparam logic [2:0] REGION_FIRST    = 3'd0;
  localparam logic [2:0] REGION_INTERP   = 3'd1;
  localparam logic [2:0] REGION_BEYOND   = 3'd2;
  localparam logic [2:0] REGION_AVERAGE  = 3'd3;
  localparam logic [2:0] REGION_FALLBACK = 3'd4;

  // register index of entry_count
  localparam logic REG_ENTRY_COUNT = 1'b0;

  typedef struct packed {
    logic [DataW-1:0] distance;
    logic [DataW-1:0] cpl;
    logic [DataW-1:0] gnd;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_LAST,
    ST_CHK_FIRST,
    ST_SEARCH,
    ST_AVG,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } ctrl_state_e;

endpackage

// ===== design/cti_req_if.sv =====
// ----------------------------------------------------------------------------
// cti_req_if
// Input item channel: table loads and spacing queries.
// ----------------------------------------------------------------------------
interface cti_req_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [3:0]         entry_index;
  logic [31:0]        entry_distance;
  logic [31:0]        entry_coupling;
  logic [31:0]        entry_ground;
  logic signed [31:0] query_spacing;

  modport source (
    output valid, func, entry_index, entry_distance, entry_coupling, entry_ground,
           query_spacing,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, entry_distance, entry_coupling, entry_ground,
           query_spacing,
    output ready
  );
endinterface

// ===== design/cti_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cti_rsp_if
// Result item channel: looked up capacitances and region code.
// ----------------------------------------------------------------------------
interface cti_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] coupling_out;
  logic [31:0] ground_out;
  logic        table_empty;
  logic [2:0]  region;

  modport source (
    output valid, coupling_out, ground_out, table_empty, region,
    input  ready
  );
  modport sink (
    input  valid, coupling_out, ground_out, table_empty, region,
    output ready
  );
endinterface

// ===== design/cap_table_interpolator.sv =====
// ----------------------------------------------------------------------------
// cap_table_interpolator
// Capacitance table with piecewise linear lookup over a shared multiply and
// bit-serial divide unit.
// ----------------------------------------------------------------------------
// Sequence: a load item is written from the idle state; a query on an empty
//   table goes straight to hand-over, else it checks the last entry, then the
//   first, then searches the segments in order and averages or interpolates
//   (two passes of multiply, 32 divide steps and fix-up), then hands over.
// Flow: one item at a time; a query holds off new items until handed over.
// Reset: rst_ni clears sequencer, result valid and entry_count; tables are not.
module cap_table_interpolator
  import cti_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cti_req_if.sink      req_i,
  cti_rsp_if.source    rsp_o,
  // APB-style register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);

  // --------------------------------------------------------------------------
  // Register port. Register 0 sits at byte address 0; bit 2 of paddr picks it.
  // --------------------------------------------------------------------------
  logic [4:0] entry_count_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_ENTRY_COUNT);
  assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? {27'b0, entry_count_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_we) begin
      entry_count_q <= pwdata[4:0];
    end
  end

  // Effective entry count, saturated at the table depth
  logic [NW-1:0] n_cur;
  assign n_cur = (32'(entry_count_q) > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
                                                        : NW'(entry_count_q);

  // --------------------------------------------------------------------------
  // Table memories: one write port (loads), one registered read port
  // --------------------------------------------------------------------------
  logic [DataW-1:0] dist_mem [TABLE_DEPTH];
  logic [DataW-1:0] cpl_mem  [TABLE_DEPTH];
  logic [DataW-1:0] gnd_mem  [TABLE_DEPTH];

  logic          req_acc;
  logic          load_we;
  logic [AW-1:0] rd_addr;
  entry_t        rdata_q;

  assign req_acc = req_i.valid && req_i.ready;
  // a slot beyond the table is dropped
  assign load_we = req_acc && (req_i.func == FUNC_LOAD) &&
                   (32'(req_i.entry_index) < 32'(TABLE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      dist_mem[AW'(req_i.entry_index)] <= req_i.entry_distance;
      cpl_mem[AW'(req_i.entry_index)]  <= req_i.entry_coupling;
      gnd_mem[AW'(req_i.entry_index)]  <= req_i.entry_ground;
    end
    rdata_q.distance <= dist_mem[rd_addr];
    rdata_q.cpl      <= cpl_mem[rd_addr];
    rdata_q.gnd      <= gnd_mem[rd_addr];
  end

  // --------------------------------------------------------------------------
  // Sequencer and shared datapath
  // --------------------------------------------------------------------------
  ctrl_state_e state_q, state_d;

  logic [NW-1:0]    n_q, n_d;
  logic [DataW-1:0] s_q, s_d;           // clamped spacing
  logic [AW-1:0]    idx_q, idx_d;       // index of entry in rdata_q while searching
  entry_t           prev_q, prev_d;     // lower end of segment
  entry_t           cur_q, cur_d;       // upper end of segment
  entry_t           last_q, last_d;
  logic [DataW-1:0] off_q, off_d;
  logic [DataW-1:0] span_q, span_d;
  logic             ch_q, ch_d;         // 0 coupling, 1 ground
  logic             neg_q, neg_d;
  logic [63:0]      prod_q, prod_d;     // product, then {remainder, quotient}
  logic [4:0]       cnt_q, cnt_d;
  logic [DataW-1:0] res_c_q, res_c_d;
  logic [DataW-1:0] res_g_q, res_g_d;
  logic             res_empty_q, res_empty_d;
  logic [2:0]       res_region_q, res_region_d;

  logic             out_valid_q, out_valid_d;
  logic             out_load;
  logic [DataW-1:0] out_c_q, out_g_q;
  logic             out_empty_q;
  logic [2:0]       out_region_q;

  // shared unit operands
  logic [DataW-1:0] v0, v1, diff, quot, fixed;
  logic [DataW:0]   trial, trial_sub;
  logic             trial_ge;
  logic [DataW:0]   sum_c, sum_g;

  always_comb begin
    v0        = ch_q ? prev_q.gnd : prev_q.cpl;
    v1        = ch_q ? cur_q.gnd  : cur_q.cpl;
    diff      = (v1 >= v0) ? (v1 - v0) : (v0 - v1);
    trial     = {prod_q[63:32], prod_q[31]};
    trial_ge  = trial >= {1'b0, span_q};
    trial_sub = trial - {1'b0, span_q};
    quot      = prod_q[31:0];
    fixed     = neg_q ? (v0 - quot) : (v0 + quot);
    sum_c     = {1'b0, prev_q.cpl} + {1'b0, cur_q.cpl};
    sum_g     = {1'b0, prev_q.gnd} + {1'b0, cur_q.gnd};
  end

  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    s_d          = s_q;
    idx_d        = idx_q;
    prev_d       = prev_q;
    cur_d        = cur_q;
    last_d       = last_q;
    off_d        = off_q;
    span_d       = span_q;
    ch_d         = ch_q;
    neg_d        = neg_q;
    prod_d       = prod_q;
    cnt_d        = cnt_q;
    res_c_d      = res_c_q;
    res_g_d      = res_g_q;
    res_empty_d  = res_empty_q;
    res_region_d = res_region_q;
    rd_addr      = '0;
    req_i.ready  = 1'b0;
    out_load     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid && (req_i.func == FUNC_QUERY)) begin
          // negative spacing clamps to zero
          s_d         = req_i.query_spacing[31] ? '0 : DataW'(req_i.query_spacing);
          n_d         = n_cur;
          res_empty_d = 1'b0;
          if (n_cur == '0) begin
            res_c_d      = '0;
            res_g_d      = '0;
            res_empty_d  = 1'b1;
            res_region_d = REGION_FIRST;
            state_d      = ST_DONE;
          end else begin
            rd_addr = AW'(n_cur - NW'(1));
            state_d = ST_CHK_LAST;
          end
        end
      end

      ST_CHK_LAST: begin
        last_d = rdata_q;
        if (s_q > rdata_q.distance) begin
          res_c_d      = '0;
          res_g_d      = rdata_q.gnd;
          res_region_d = REGION_BEYOND;
          state_d      = ST_DONE;
        end else begin
          rd_addr = '0;
          state_d = ST_CHK_FIRST;
        end
      end

      ST_CHK_FIRST: begin
        if (s_q <= rdata_q.distance) begin
          res_c_d      = rdata_q.cpl;
          res_g_d      = rdata_q.gnd;
          res_region_d = REGION_FIRST;
          state_d      = ST_DONE;
        end else begin
          // here at least two entries exist
          prev_d  = rdata_q;
          idx_d   = AW'(1);
          rd_addr = AW'(1);
          state_d = ST_SEARCH;
        end
      end

      ST_SEARCH: begin
        if ((prev_q.distance <= s_q) && (s_q <= rdata_q.distance)) begin
          cur_d  = rdata_q;
          off_d  = s_q - prev_q.distance;
          span_d = rdata_q.distance - prev_q.distance;
          ch_d   = 1'b0;
          if (rdata_q.distance == prev_q.distance) begin
            state_d = ST_AVG;
          end else begin
            state_d = ST_MUL;
          end
        end else if ((32'(idx_q) + 32'd1) < 32'(n_q)) begin
          prev_d  = rdata_q;
          idx_d   = idx_q + AW'(1);
          rd_addr = idx_q + AW'(1);
        end else begin
          res_c_d      = last_q.cpl;
          res_g_d      = last_q.gnd;
          res_region_d = REGION_FALLBACK;
          state_d      = ST_DONE;
        end
      end

      ST_AVG: begin
        res_c_d      = sum_c[DataW:1];
        res_g_d      = sum_g[DataW:1];
        res_region_d = REGION_AVERAGE;
        state_d      = ST_DONE;
      end

      ST_MUL: begin
        neg_d   = v1 < v0;
        prod_d  = 64'(diff) * 64'(off_q);
        cnt_d   = '0;
        state_d = ST_DIV;
      end

      // restoring division, one quotient bit a cycle; high half < span always
      ST_DIV: begin
        prod_d = {(trial_ge ? trial_sub[DataW-1:0] : trial[DataW-1:0]),
                  prod_q[30:0], trial_ge};
        cnt_d  = cnt_q + 5'd1;
        if (cnt_q == 5'(DivSteps - 1)) begin
          state_d = ST_FIX;
        end
      end

      ST_FIX: begin
        if (!ch_q) begin
          res_c_d = fixed;
          ch_d    = 1'b1;
          state_d = ST_MUL;
        end else begin
          res_g_d      = fixed;
          res_region_d = REGION_INTERP;
          state_d      = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !rsp_o.ready) || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q          <= n_d;
    s_q          <= s_d;
    idx_q        <= idx_d;
    prev_q       <= prev_d;
    cur_q        <= cur_d;
    last_q       <= last_d;
    off_q        <= off_d;
    span_q       <= span_d;
    ch_q         <= ch_d;
    neg_q        <= neg_d;
    prod_q       <= prod_d;
    cnt_q        <= cnt_d;
    res_c_q      <= res_c_d;
    res_g_q      <= res_g_d;
    res_empty_q  <= res_empty_d;
    res_region_q <= res_region_d;
    if (out_load) begin
      out_c_q      <= res_c_q;
      out_g_q      <= res_g_q;
      out_empty_q  <= res_empty_q;
      out_region_q <= res_region_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.coupling_out = out_c_q;
  assign rsp_o.ground_out   = out_g_q;
  assign rsp_o.table_empty  = out_empty_q;
  assign rsp_o.region       = out_region_q;

endmodule

// ===== tb/cti_lookup_checker.sv =====
// ----------------------------------------------------------------------------
// cti_lookup_checker
// Watches the item channels and the register port of the capacitance table
// interpolator, predicts each query's lookup and compares it with the result.
// ----------------------------------------------------------------------------
module cti_lookup_checker
  import cti_pkg::*;
#(
  parameter int unsigned TableDepth = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cti_req_if          req_i,
  cti_rsp_if          rsp_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          owed_o
);

  localparam logic [2:0] EntryCountAddr = {REG_ENTRY_COUNT, 2'b00};

  typedef struct packed {
    logic [31:0] coupling;
    logic [31:0] ground;
    logic        empty;
    logic [2:0]  region;
  } cap_lookup_t;

  // shadow of the table and of entry_count
  logic [31:0] dist_tab [TableDepth];
  logic [31:0] cpl_tab  [TableDepth];
  logic [31:0] gnd_tab  [TableDepth];
  logic [4:0]  entry_count_q = '0;

  cap_lookup_t lookups_owed [$];
  int          mismatches = 0;

  // linear step from v0 towards v1, quotient truncated
  function automatic logic [31:0] lerp(input logic [31:0] v0, input logic [31:0] v1,
                                       input logic [31:0] off, input logic [31:0] span);
    logic [63:0] mag;
    if (v1 >= v0) begin
      mag = (64'(v1 - v0) * 64'(off)) / 64'(span);
      return v0 + mag[31:0];
    end
    mag = (64'(v0 - v1) * 64'(off)) / 64'(span);
    return v0 - mag[31:0];
  endfunction

  function automatic logic [31:0] mean(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32:1];
  endfunction

  function automatic cap_lookup_t lookup(input logic [31:0] spacing);
    cap_lookup_t r;
    logic [31:0] s;
    logic [31:0] d0;
    logic [31:0] d1;
    int          n;
    int          last;
    r = '0;
    n = (entry_count_q > TableDepth) ? TableDepth : int'(entry_count_q);
    s = spacing[31] ? 32'd0 : spacing;
    if (n == 0) begin
      r.empty  = 1'b1;
      r.region = REGION_FIRST;
    end else begin
      last = n - 1;
      if (s > dist_tab[last]) begin
        r.ground = gnd_tab[last];
        r.region = REGION_BEYOND;
      end else if (s <= dist_tab[0]) begin
        r.coupling = cpl_tab[0];
        r.ground   = gnd_tab[0];
        r.region   = REGION_FIRST;
      end else begin
        r.coupling = cpl_tab[last];
        r.ground   = gnd_tab[last];
        r.region   = REGION_FALLBACK;
        for (int i = 0; i + 1 < n; i++) begin
          d0 = dist_tab[i];
          d1 = dist_tab[i+1];
          if (d0 <= s && s <= d1) begin
            if (d1 == d0) begin
              r.coupling = mean(cpl_tab[i], cpl_tab[i+1]);
              r.ground   = mean(gnd_tab[i], gnd_tab[i+1]);
              r.region   = REGION_AVERAGE;
            end else begin
              r.coupling = lerp(cpl_tab[i], cpl_tab[i+1], s - d0, d1 - d0);
              r.ground   = lerp(gnd_tab[i], gnd_tab[i+1], s - d0, d1 - d0);
              r.region   = REGION_INTERP;
            end
            break;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    cap_lookup_t want;
    if (rst_ni) begin
      if (psel && penable && pready && paddr == EntryCountAddr) begin
        if (pwrite) begin
          entry_count_q = pwdata[4:0];
        end else begin
          check_field("entry_count readback", 32'(entry_count_q), prdata);
        end
      end

      if (req_i.valid && req_i.ready) begin
        if (req_i.func == FUNC_LOAD) begin
          dist_tab[req_i.entry_index] = req_i.entry_distance;
          cpl_tab[req_i.entry_index]  = req_i.entry_coupling;
          gnd_tab[req_i.entry_index]  = req_i.entry_ground;
        end else begin
          lookups_owed.insert(lookups_owed.size(), lookup(req_i.query_spacing));
        end
      end

      if (rsp_i.valid && rsp_i.ready) begin
        if (lookups_owed.size() == 0) begin
          mismatches++;
          $display("%0t: result item with none owed: expected none, actual %h %h %b %0d",
                   $time, rsp_i.coupling_out, rsp_i.ground_out, rsp_i.table_empty,
                   rsp_i.region);
        end else begin
          want = lookups_owed.pop_front();
          check_field("coupling_out", want.coupling, rsp_i.coupling_out);
          check_field("ground_out", want.ground, rsp_i.ground_out);
          check_field("table_empty", 32'(want.empty), 32'(rsp_i.table_empty));
          check_field("region", 32'(want.region), 32'(rsp_i.region));
        end
      end
    end
    owed_o       <= lookups_owed.size();
    fail_count_o <= mismatches;
  end

endmodule

// ===== tb/tb_cap_table_interpolator.sv =====
// ----------------------------------------------------------------------------
// tb_cap_table_interpolator
// Drives table loads, entry_count writes and spacing queries into the
// interpolator, with random bursts on the input side and random stalls on
// the result side; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_cap_table_interpolator;
  import cti_pkg::*;

  localparam int unsigned TableDepth     = 16;
  localparam logic [2:0]  EntryCountAddr = {REG_ENTRY_COUNT, 2'b00};
  localparam int          RandomItems    = 1850;
  // pause that outlasts the worst query with margin
  localparam int          LatencyPause   = 100;
  // cycles without any handshake before the run is declared hung
  localparam int          StallLimit     = 3000;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_RARELY,
    RDY_TOGGLE
  } ready_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cti_req_if req_if ();
  cti_rsp_if rsp_if ();

  int          fail_count;
  int          owed;
  int          items_driven;
  int          burst_left;
  int          idle_cycles;
  ready_mode_e ready_mode;
  int          ready_span;

  // distances last loaded per slot, used only to aim queries at the table
  logic [31:0] aim_dist [TableDepth];

  cap_table_interpolator #(
    .TABLE_DEPTH(TableDepth)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  cti_lookup_checker #(
    .TableDepth(TableDepth)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .fail_count_o(fail_count),
    .owed_o      (owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side back-pressure: stretches of random length, each with its own
  // pattern, so stalls land on every phase of the sequencer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      ready_mode   <= RDY_ALWAYS;
      ready_span   <= 0;
    end else begin
      if (ready_span == 0) begin
        ready_mode <= ready_mode_e'($urandom_range(0, 3));
        ready_span <= $urandom_range(4, 80);
      end else begin
        ready_span <= ready_span - 1;
      end
      case (ready_mode)
        RDY_ALWAYS: rsp_if.ready <= 1'b1;
        RDY_MOSTLY: rsp_if.ready <= ($urandom_range(0, 3) != 0);
        RDY_RARELY: rsp_if.ready <= ($urandom_range(0, 3) == 0);
        default:    rsp_if.ready <= ~rsp_if.ready;
      endcase
    end
  end

  // Hang detector: any handshake on either channel or the register port
  // restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
        || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("cap_table_interpolator verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One item onto the input channel. Items go out in bursts; between bursts
  // valid drops for a random gap, and some bursts are long with no gap.
  task automatic drive_item(input logic func, input logic [3:0] idx,
                            input logic [31:0] dst, input logic [31:0] cpl,
                            input logic [31:0] gnd, input logic [31:0] spacing);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 16);
    end
    req_if.valid          <= 1'b1;
    req_if.func           <= func;
    req_if.entry_index    <= idx;
    req_if.entry_distance <= dst;
    req_if.entry_coupling <= cpl;
    req_if.entry_ground   <= gnd;
    req_if.query_spacing  <= spacing;
    do @(posedge clk_i); while (!req_if.ready);
    burst_left--;
    items_driven++;
  endtask

  // unused fields carry noise so every bit moves
  task automatic send_load(input logic [3:0] idx, input logic [31:0] dst,
                           input logic [31:0] cpl, input logic [31:0] gnd);
    aim_dist[idx] = dst;
    drive_item(FUNC_LOAD, idx, dst, cpl, gnd, $urandom);
  endtask

  task automatic send_query(input logic [31:0] spacing);
    drive_item(FUNC_QUERY, 4'($urandom), $urandom, $urandom, $urandom, spacing);
  endtask

  // Block idle: input quiet, every result back, then a pause for a trailing
  // load still in flight. The first edge lets the checker's count catch up.
  task automatic settle();
    req_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (owed != 0) @(posedge clk_i);
    repeat (LatencyPause) @(posedge clk_i);
  endtask

  // Write entry_count, then read it straight back (psel held across both).
  task automatic program_count(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= EntryCountAddr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Load slots 0..m-1. Distance styles: mostly small ascending steps with
  // repeats, spread up to the largest positive spacing, spread over the full
  // unsigned range, or unsorted. Capacitances random, at the rails, smooth,
  // or of mixed magnitude.
  task automatic build_table(input int m);
    int                dmode;
    int                vmode;
    longint unsigned   prev;
    longint unsigned   room;
    longint unsigned   step;
    logic [31:0]       d;
    logic [31:0]       c;
    logic [31:0]       g;
    dmode = $urandom_range(0, 9);
    vmode = $urandom_range(0, 3);
    prev  = 0;
    c     = $urandom;
    g     = $urandom;
    for (int k = 0; k < m; k++) begin
      if (dmode <= 4) begin
        if (k == 0)                        step = $urandom_range(0, 32'h0004_0000);
        else if ($urandom_range(0, 7) == 0) step = 0;
        else                               step = $urandom_range(1, 32'h0008_0000);
      end else begin
        room = ((dmode <= 6) ? 64'h7FFF_FFFF : 64'hFFFF_FFFF) - prev;
        step = $urandom_range(0, 32'(room / longint'(m - k)));
      end
      d    = (dmode == 9) ? $urandom : 32'(prev + step);
      prev = d;
      case (vmode)
        0: begin
          c = $urandom;
          g = $urandom;
        end
        1: begin
          c = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
          g = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        end
        2: begin
          c = c + 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
          g = g + 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
        end
        default: begin
          c = $urandom >> $urandom_range(0, 31);
          g = $urandom >> $urandom_range(0, 31);
        end
      endcase
      send_load(4'(k), d, c, g);
    end
  endtask

  // Spacing aimed at the loaded table: negatives, zero, exact distances,
  // inside a segment, just past the end, neighbours of a distance, extremes.
  function automatic logic [31:0] pick_spacing(input int m);
    int          k;
    logic [31:0] lo;
    logic [31:0] hi;
    if (m == 0) return $urandom;
    k  = $urandom_range(0, m - 1);
    lo = aim_dist[k];
    hi = (k + 1 < m) ? aim_dist[k+1] : lo;
    case ($urandom_range(0, 9))
      0:       return {1'b1, 31'($urandom)};
      1:       return 32'h0;
      2:       return lo;
      3, 4, 5: return (hi > lo) ? lo + $urandom_range(0, hi - lo) : lo;
      6:       return aim_dist[m-1] + $urandom_range(1, 256);
      7:       return $urandom;
      8:       return lo + $urandom_range(0, 2) - 32'd1;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  // One random phase: pick a count (empty, one entry, full, above the depth
  // now and then), load the table, then queries with the odd stray load.
  // A stray load into a live slot can leave the distances out of order.
  task automatic run_phase();
    int n;
    int m;
    int queries;
    case ($urandom_range(0, 19))
      0:       n = 0;
      1:       n = 1;
      2, 3:    n = TableDepth;
      4:       n = $urandom_range(TableDepth + 1, 31);
      default: n = $urandom_range(2, TableDepth - 1);
    endcase
    m = (n > TableDepth) ? TableDepth : n;
    settle();
    program_count(n);
    build_table(m);
    queries = $urandom_range(8, 50);
    repeat (queries) begin
      if ($urandom_range(0, 9) == 0) begin
        send_load(4'($urandom), $urandom, $urandom, $urandom);
      end
      send_query(pick_spacing(m));
    end
  endtask

  initial begin
    int random_start;
    rst_ni                <= 1'b0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    req_if.valid          <= 1'b0;
    req_if.func           <= FUNC_LOAD;
    req_if.entry_index    <= '0;
    req_if.entry_distance <= '0;
    req_if.entry_coupling <= '0;
    req_if.entry_ground   <= '0;
    req_if.query_spacing  <= '0;
    items_driven = 0;
    burst_left   = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table straight after reset: most negative, zero, most positive
    send_query(32'h8000_0000);
    send_query(32'h0000_0000);
    send_query(32'h7FFF_FFFF);

    // three entries: rising coupling, falling ground, then a falling segment
    send_load(4'd0, 32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_load(4'd1, 32'h0003_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    send_load(4'd2, 32'h0005_0000, 32'h1000_0000, 32'h1000_0000);
    settle();
    program_count(3);
    send_query(32'hFFFF_FFFF);   // negative, clamps to zero
    send_query(32'h0001_0000);   // exactly the first distance
    send_query(32'h0002_0000);   // mid segment
    send_query(32'h0002_8000);   // truncated quotient
    send_query(32'h0003_0000);   // on an inner distance
    send_query(32'h0004_0001);   // falling segment
    send_query(32'h0005_0000);   // exactly the last distance
    send_query(32'h0005_0001);   // just past the end
    send_query(32'h7FFF_FFFF);

    // last distance below the middle one: out-of-order table
    send_load(4'd2, 32'h0002_0000, 32'h1234_5678, 32'h8765_4321);
    send_query(32'h0002_8000);
    send_query(32'h0001_8000);

    // single entry
    settle();
    program_count(1);
    send_query(32'h0000_0000);
    send_query(32'h0002_0000);

    random_start = items_driven;
    while (items_driven - random_start < RandomItems) run_phase();

    settle();
    if (fail_count == 0) begin
      $display("cap_table_interpolator verification clean");
    end else begin
      $display("cap_table_interpolator verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/cti_pkg.sv
design/cti_req_if.sv
design/cti_rsp_if.sv
design/cap_table_interpolator.sv
tb/cti_lookup_checker.sv
tb/tb_cap_table_interpolator.sv
